// ===== rtl/core/ssdg_pkg.sv =====
// ---------------------------------------------------------------------------
// ssdg_pkg: shared types and constants
// Field widths, mode codes, register indexes and the queue entry for the
// step/dir generator.
// ---------------------------------------------------------------------------
package ssdg_pkg;
    localparam int unsigned PW_W   = 8;
    localparam int unsigned SD_W   = 8;
    localparam int unsigned RN_W   = 20;
    localparam int unsigned SPR_W  = 16;
    localparam int unsigned VEL_W  = 16;
    localparam int unsigned DEG_W  = 20;
    localparam int unsigned ID_W   = 2;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned LOW_W  = 17;
    localparam int unsigned MASK_W = 3;
    localparam logic [LOW_W-1:0] LOW_MAX = '1;
    localparam logic [8:0] DEG_PER_REV = 9'd360;

    // x / 360 == (x * RCP_360) >> RCP_SH for every x below 2^28
    localparam int unsigned RCP_W  = 26;
    localparam int unsigned RCP_SH = 34;
    localparam logic [RCP_W-1:0] RCP_360 = 26'd47721859;

    // configuration register indexes
    localparam logic [1:0] REG_PULSE_WIDTH = 2'd0;
    localparam logic [1:0] REG_START_DELAY = 2'd1;
    localparam logic [1:0] REG_RATE_NUM    = 2'd2;
    localparam logic [1:0] REG_STEPS_REV   = 2'd3;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_VEL   = 2'd1,
        MODE_MOVE  = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    // one classified item between front and back
    typedef struct packed {
        mode_t              mode;
        logic [ID_W-1:0]    motor_id;
        logic               id_ok;
        logic [VEL_W-1:0]   vel;
        logic [LOW_W-1:0]   low;
        logic [CNT_W-1:0]   cnt;
    } cmd_t;
endpackage

// ===== rtl/core/ssdg_front.sv =====
// ---------------------------------------------------------------------------
// ssdg_front: command classifier and arithmetic
// Takes items, works out low period (serial divide) and step count of a
// degree move (reciprocal multiplies for the divide by 360), pushes a command.
// ---------------------------------------------------------------------------
module ssdg_front #(
    parameter int unsigned MOTORS = 3
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               in_mode,
    input  logic [ssdg_pkg::ID_W-1:0]  in_id,
    input  logic [ssdg_pkg::VEL_W-1:0] in_vel,
    input  logic [ssdg_pkg::DEG_W-1:0] in_deg,
    input  logic [ssdg_pkg::PW_W-1:0]  pulse_width,
    input  logic [ssdg_pkg::RN_W-1:0]  rate_numerator,
    input  logic [ssdg_pkg::SPR_W-1:0] steps_per_rev,
    output logic                     out_valid,
    input  logic                     out_ready,
    output ssdg_pkg::cmd_t           out_cmd
);
    import ssdg_pkg::*;

    localparam int unsigned ITER_W = 5;
    localparam int unsigned QD_W   = 12;                      // degree / 360
    localparam int unsigned REM_W  = 9;                       // degree % 360
    localparam int unsigned HI_W   = QD_W + SPR_W;
    localparam int unsigned PART_W = REM_W + SPR_W;
    localparam int unsigned LO_W   = PART_W + RCP_W - RCP_SH;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_QD, S_REM, S_PART, S_CNT, S_OUT
    } state_t;

    state_t             state_reg;
    cmd_t               cmd_reg;
    logic [RN_W-1:0]    quo_reg;    // dividend shifts out, quotient in
    logic [VEL_W-1:0]   rem_reg;
    logic [VEL_W-1:0]   divisor_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic [DEG_W-1:0]   deg_reg;
    logic [QD_W-1:0]    qd_reg;
    logic [REM_W-1:0]   rd_reg;
    logic [HI_W-1:0]    hi_reg;
    logic [PART_W-1:0]  part_reg;

    logic [VEL_W-1:0]        mag;
    logic [VEL_W:0]          rem_sh;
    logic                    sub_ok;
    logic [RN_W-1:0]         q_fin;
    logic [DEG_W+RCP_W-1:0]  qd_prod;
    logic [DEG_W-1:0]        rd_full;
    logic [PART_W+RCP_W-1:0] lo_prod;

    assign mag    = in_vel[VEL_W-1] ? VEL_W'(-in_vel) : in_vel;
    assign rem_sh = {rem_reg, quo_reg[RN_W-1]};
    assign sub_ok = rem_sh >= (VEL_W+1)'(divisor_reg);
    assign q_fin  = {quo_reg[RN_W-2:0], sub_ok};
    // degree * spr / 360 == (degree / 360) * spr + (degree % 360) * spr / 360
    assign qd_prod = (DEG_W+RCP_W)'(deg_reg) * (DEG_W+RCP_W)'(RCP_360);
    assign rd_full = deg_reg - DEG_W'(qd_reg) * DEG_W'(DEG_PER_REV);
    assign lo_prod = (PART_W+RCP_W)'(part_reg) * (PART_W+RCP_W)'(RCP_360);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_cmd   = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        cmd_reg.mode     <= mode_t'(in_mode);
                        cmd_reg.motor_id <= in_id;
                        cmd_reg.id_ok    <= 32'(in_id) < MOTORS;
                        cmd_reg.vel      <= in_vel;
                        cmd_reg.low      <= '0;
                        cmd_reg.cnt      <= '0;
                        deg_reg  <= in_deg;
                        quo_reg  <= rate_numerator;
                        rem_reg  <= '0;
                        divisor_reg <= mag;
                        iter_reg <= ITER_W'(RN_W);
                        if ((in_mode == MODE_VEL || in_mode == MODE_MOVE)
                                && mag != '0)
                            state_reg <= S_DIV;
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    rem_reg <= sub_ok ? VEL_W'(rem_sh - (VEL_W+1)'(divisor_reg))
                                      : rem_sh[VEL_W-1:0];
                    quo_reg <= q_fin;
                    iter_reg <= iter_reg - 1'b1;
                    if (iter_reg == ITER_W'(1)) begin
                        if (q_fin <= RN_W'(pulse_width))
                            cmd_reg.low <= LOW_W'(1);
                        else if (q_fin - RN_W'(pulse_width) > RN_W'(LOW_MAX))
                            cmd_reg.low <= LOW_MAX;
                        else
                            cmd_reg.low <= LOW_W'(q_fin - RN_W'(pulse_width));
                        if (cmd_reg.mode == MODE_MOVE)
                            state_reg <= S_QD;
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_QD: begin
                    qd_reg <= qd_prod[RCP_SH +: QD_W];
                    state_reg <= S_REM;
                end
                S_REM: begin
                    rd_reg <= rd_full[REM_W-1:0];
                    hi_reg <= HI_W'(qd_reg) * HI_W'(steps_per_rev);
                    state_reg <= S_PART;
                end
                S_PART: begin
                    part_reg <= PART_W'(rd_reg) * PART_W'(steps_per_rev);
                    state_reg <= S_CNT;
                end
                S_CNT: begin
                    cmd_reg.cnt <= CNT_W'(hi_reg) + CNT_W'(lo_prod[RCP_SH +: LO_W]);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/ssdg_queue.sv =====
// ---------------------------------------------------------------------------
// ssdg_queue: two-entry command queue
// Decouples the classifier from the motor engine.
// ---------------------------------------------------------------------------
module ssdg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ssdg_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output ssdg_pkg::cmd_t out_cmd
);
    import ssdg_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_cmd   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_cmd;
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== rtl/core/ssdg_engine.sv =====
// ---------------------------------------------------------------------------
// ssdg_engine: per-motor pulse state and result register
// Applies one command per cycle unless stalled; holds the result until taken.
// ---------------------------------------------------------------------------
module ssdg_engine #(
    parameter int unsigned MOTORS = 3
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ssdg_pkg::cmd_t             in_cmd,
    input  logic [ssdg_pkg::PW_W-1:0]  pulse_width,
    input  logic [ssdg_pkg::SD_W-1:0]  start_delay,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [63:0]                out_data
);
    import ssdg_pkg::*;

    logic [VEL_W-1:0] speed_reg     [MOTORS];
    logic [LOW_W-1:0] low_reg       [MOTORS];
    logic [LOW_W-1:0] cd_reg        [MOTORS];
    logic             high_reg      [MOTORS];
    logic             pend_reg      [MOTORS];
    logic             act_reg       [MOTORS];
    logic [CNT_W-1:0] steps_reg     [MOTORS];
    logic [CNT_W-1:0] tgt_reg       [MOTORS];
    logic             stp_reg       [MOTORS];
    logic             dir_reg       [MOTORS];

    logic [VEL_W-1:0] speed_next    [MOTORS];
    logic [LOW_W-1:0] low_next      [MOTORS];
    logic [LOW_W-1:0] cd_next       [MOTORS];
    logic             high_next     [MOTORS];
    logic             pend_next     [MOTORS];
    logic             act_next      [MOTORS];
    logic [CNT_W-1:0] steps_next    [MOTORS];
    logic [CNT_W-1:0] tgt_next      [MOTORS];
    logic             stp_next      [MOTORS];
    logic             dir_next      [MOTORS];

    logic             valid_reg;
    logic [63:0]      data_reg;
    logic [63:0]      data_next;
    logic             take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        logic [MASK_W-1:0] sp, dp, rm, im;
        logic [CNT_W-1:0]  sc;
        logic [VEL_W-1:0]  vo;
        sp = '0; dp = '0; rm = '0; im = '0; sc = '0; vo = '0;
        for (int m = 0; m < MOTORS; m++) begin
            speed_next[m] = speed_reg[m]; low_next[m] = low_reg[m];
            cd_next[m] = cd_reg[m]; high_next[m] = high_reg[m];
            pend_next[m] = pend_reg[m]; act_next[m] = act_reg[m];
            steps_next[m] = steps_reg[m]; tgt_next[m] = tgt_reg[m];
            stp_next[m] = stp_reg[m]; dir_next[m] = dir_reg[m];
            if (in_cmd.mode == MODE_TICK) begin
                if (act_reg[m]) begin
                    if (cd_reg[m] > LOW_W'(1)) begin
                        cd_next[m] = cd_reg[m] - 1'b1;
                    end else if (!high_reg[m]) begin
                        stp_next[m] = 1'b1;
                        high_next[m] = 1'b1;
                        cd_next[m] = LOW_W'(pulse_width);
                    end else begin
                        stp_next[m] = 1'b0;
                        if (speed_reg[m] != '0)
                            steps_next[m] = speed_reg[m][VEL_W-1] ?
                                steps_reg[m] - 1'b1 : steps_reg[m] + 1'b1;
                        if (steps_next[m] == tgt_reg[m]) begin
                            // stop: same as a zero-speed command
                            if (speed_reg[m] != '0) begin
                                pend_next[m] = 1'b1;
                                speed_next[m] = '0;
                                low_next[m] = '0;
                            end
                            tgt_next[m] = steps_next[m];
                        end
                        if (pend_next[m]) begin
                            if (speed_next[m] == '0) act_next[m] = 1'b0;
                            else dir_next[m] = !speed_next[m][VEL_W-1];
                            pend_next[m] = 1'b0;
                        end
                        cd_next[m] = low_next[m];
                        high_next[m] = 1'b0;
                    end
                end
            end else if ((in_cmd.mode == MODE_VEL || in_cmd.mode == MODE_MOVE)
                         && in_cmd.id_ok && 32'(in_cmd.motor_id) == m) begin
                if (speed_reg[m] == '0 && in_cmd.vel == '0) begin
                    tgt_next[m] = steps_reg[m];
                end else begin
                    if (speed_reg[m] == '0) begin
                        dir_next[m] = !in_cmd.vel[VEL_W-1];
                        cd_next[m] = LOW_W'(start_delay);
                        act_next[m] = 1'b1;
                    end else begin
                        pend_next[m] = 1'b1;
                    end
                    speed_next[m] = in_cmd.vel;
                    low_next[m] = in_cmd.low;
                    tgt_next[m] = steps_reg[m];
                end
                if (in_cmd.mode == MODE_MOVE && in_cmd.vel != '0)
                    tgt_next[m] = in_cmd.vel[VEL_W-1] ?
                        steps_reg[m] - in_cmd.cnt : steps_reg[m] + in_cmd.cnt;
            end
            if (m < MASK_W) begin
                sp[m] = stp_next[m]; dp[m] = dir_next[m];
                rm[m] = act_next[m]; im[m] = steps_next[m] == tgt_next[m];
            end
            if (in_cmd.id_ok && 32'(in_cmd.motor_id) == m) begin
                sc = steps_next[m];
                vo = speed_next[m];
            end
        end
        data_next = {4'b0, vo, sc, im, rm, dp, sp};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            for (int m = 0; m < MOTORS; m++) begin
                speed_reg[m] <= '0; low_reg[m] <= '0; cd_reg[m] <= '0;
                high_reg[m] <= 1'b0; pend_reg[m] <= 1'b0; act_reg[m] <= 1'b0;
                steps_reg[m] <= '0; tgt_reg[m] <= '0;
                stp_reg[m] <= 1'b0; dir_reg[m] <= 1'b0;
            end
        end else begin
            if (take) begin
                valid_reg <= 1'b1;
                data_reg <= data_next;
                for (int m = 0; m < MOTORS; m++) begin
                    speed_reg[m] <= speed_next[m]; low_reg[m] <= low_next[m];
                    cd_reg[m] <= cd_next[m]; high_reg[m] <= high_next[m];
                    pend_reg[m] <= pend_next[m]; act_reg[m] <= act_next[m];
                    steps_reg[m] <= steps_next[m]; tgt_reg[m] <= tgt_next[m];
                    stp_reg[m] <= stp_next[m]; dir_reg[m] <= dir_next[m];
                end
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end
endmodule

// ===== rtl/core/stepper_step_dir_generator.sv =====
// ---------------------------------------------------------------------------
// stepper_step_dir_generator: step/dir pulse generator for stepper motors
// Top level: config registers, classifier, queue and motor engine.
// ---------------------------------------------------------------------------
// Each item gives exactly one result. The front accepts a tick or a query,
// then hands it off, and its result goes on through the queue and engine
// when the queue and output are free. A velocity command first runs the
// bit-serial divider (rate_numerator / |velocity|); a degree move then adds
// the reciprocal multiplies for the divide by 360. The front takes no new
// item until it has handed the current one on to the queue.
// A two-entry queue lets the front classify the next item while the engine
// applies the previous one, and the engine holds each result in an output
// register. Write configuration only while the block is idle.
module stepper_step_dir_generator #(
    parameter int unsigned MOTORS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] mode, [3:2] motor_id, [19:4] velocity_cmd, [39:20] degree_cmd
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] step_pins, [5:3] dir_pins, [8:6] running_mask, [11:9] idle_mask,
    // [43:12] step_count_out, [59:44] velocity_out
    output logic [63:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import ssdg_pkg::*;

    logic [PW_W-1:0]  pw_reg;
    logic [SD_W-1:0]  sd_reg;
    logic [RN_W-1:0]  rn_reg;
    logic [SPR_W-1:0] spr_reg;

    // hold config; take a write on any cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_reg <= 8'd2;
            sd_reg <= 8'd5;
            rn_reg <= 20'd100000;
            spr_reg <= 16'd200;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PULSE_WIDTH: pw_reg <= cfg_data[PW_W-1:0];
                REG_START_DELAY: sd_reg <= cfg_data[SD_W-1:0];
                REG_RATE_NUM:    rn_reg <= cfg_data;
                REG_STEPS_REV:   spr_reg <= cfg_data[SPR_W-1:0];
                default: ;
            endcase
        end
    end

    logic f_valid, f_ready, q_valid, q_ready;
    cmd_t f_cmd, q_cmd;

    ssdg_front #(.MOTORS(MOTORS)) u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_mode(s_tdata[1:0]), .in_id(s_tdata[3:2]),
        .in_vel(s_tdata[19:4]), .in_deg(s_tdata[39:20]),
        .pulse_width(pw_reg), .rate_numerator(rn_reg), .steps_per_rev(spr_reg),
        .out_valid(f_valid), .out_ready(f_ready), .out_cmd(f_cmd)
    );

    ssdg_queue u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    ssdg_engine #(.MOTORS(MOTORS)) u_engine (
        .aclk, .aresetn,
        .in_valid(q_valid), .in_ready(q_ready), .in_cmd(q_cmd),
        .pulse_width(pw_reg), .start_delay(sd_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );
endmodule

// ===== rtl/core/ssdg_checker.sv =====
// ---------------------------------------------------------------------------
// ssdg_checker: port-level checks
// Watches the stream ports of the step/dir generator.
// ---------------------------------------------------------------------------
module ssdg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:60] == 4'b0) else $error("pad bits set");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("valid after reset");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("front took two items");
endmodule

bind stepper_step_dir_generator ssdg_checker u_ssdg_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
